FILE: rtl/bfl_pkg.sv
`default_nettype none
package bfl_pkg;

    // Pool geometry
    localparam int NUM_BUFS = 64;
    localparam int ID_W     = $clog2(NUM_BUFS);
    localparam int CNT_W    = ID_W + 1;

    // Function codes
    localparam logic [2:0] FN_ALLOC = 3'd0;
    localparam logic [2:0] FN_FREE  = 3'd1;
    localparam logic [2:0] FN_MARK  = 3'd2;
    localparam logic [2:0] FN_QUERY = 3'd3;
    localparam logic [2:0] FN_RESET = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Reset value of the pool size register
    localparam logic [CNT_W-1:0] POOL_SIZE_RST = CNT_W'(NUM_BUFS);

    typedef struct packed {
        logic [2:0]      func;
        logic [ID_W-1:0] buffer_id;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  granted_id;
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] used_count;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic finish;
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pop_go;
    } t_dp_sts;

endpackage
`default_nettype wire

FILE: rtl/bfl_ctrl.sv
`default_nettype none
module bfl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bfl_pkg::t_dp_sts  i_sts,
    output bfl_pkg::t_ctl_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    assign busy = (r_state == S_POP);

    // Issue commands to the datapath
    always_comb begin
        o_cmd.accept = start && !busy;
        o_cmd.finish = (r_state == S_POP);
    end

    // Advance: a pop waits in S_POP for the registered stack read
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_sts.pop_go) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/bfl_dp.sv
`default_nettype none
module bfl_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bfl_pkg::CNT_W-1:0]     i_cfg_wdata,
    input  wire bfl_pkg::t_cmd                 i_cmd,
    input  wire bfl_pkg::t_ctl_cmd             i_ctl,
    output bfl_pkg::t_dp_sts                   o_sts,
    output logic                               o_valid,
    output bfl_pkg::t_rsp                      o_rsp
);

    localparam int ID_W  = bfl_pkg::ID_W;
    localparam int CNT_W = bfl_pkg::CNT_W;

    // Free stack storage
    logic [ID_W-1:0] mem [bfl_pkg::NUM_BUFS];
    logic [ID_W-1:0] r_rdata;

    logic [CNT_W-1:0] r_pool_size;
    logic [CNT_W-1:0] r_active, n_active;
    logic [CNT_W-1:0] r_top,    n_top;
    logic [CNT_W-1:0] r_hand,   n_hand;
    // Lowest top since the last reload: entries below it read back as their own index
    logic [CNT_W-1:0] r_low,    n_low;
    logic [ID_W-1:0]  r_pop_idx, n_pop_idx;
    logic             r_pop_orig, n_pop_orig;
    logic             r_valid,  n_valid;
    bfl_pkg::t_rsp    r_rsp,    n_rsp;
    logic [bfl_pkg::NUM_BUFS-1:0] r_in_use;

    logic [CNT_W-1:0] top_m1;
    logic [ID_W-1:0]  rd_addr;
    logic [CNT_W-1:0] clamp_size;
    logic             id_ok;
    logic             do_push;
    logic             do_set;
    logic             do_clr;
    logic             do_reload;
    logic [1:0]       st;

    assign top_m1  = r_top - CNT_W'(1);
    assign rd_addr = top_m1[ID_W-1:0];
    assign id_ok   = ({1'b0, i_cmd.buffer_id} < r_active);

    assign o_sts.pop_go = (i_cmd.func == bfl_pkg::FN_ALLOC) && (r_top != '0);
    assign o_valid      = r_valid;
    assign o_rsp        = r_rsp;

    // Clamp the configured size into 1..NUM_BUFS
    always_comb begin
        if (r_pool_size == '0) begin
            clamp_size = CNT_W'(1);
        end else if (r_pool_size > CNT_W'(bfl_pkg::NUM_BUFS)) begin
            clamp_size = CNT_W'(bfl_pkg::NUM_BUFS);
        end else begin
            clamp_size = r_pool_size;
        end
    end

    // Execute one command
    always_comb begin
        n_active   = r_active;
        n_top      = r_top;
        n_hand     = r_hand;
        n_low      = r_low;
        n_pop_idx  = r_pop_idx;
        n_pop_orig = r_pop_orig;
        n_valid    = 1'b0;
        n_rsp      = r_rsp;
        do_push    = 1'b0;
        do_set     = 1'b0;
        do_clr     = 1'b0;
        do_reload  = 1'b0;
        st         = bfl_pkg::ST_OK;
        if (i_ctl.finish) begin
            n_valid          = 1'b1;
            n_rsp.status     = bfl_pkg::ST_OK;
            n_rsp.granted_id = r_pop_orig ? r_pop_idx : r_rdata;
            n_rsp.free_count = r_top;
            n_rsp.used_count = r_hand;
        end else if (i_ctl.accept) begin
            unique case (i_cmd.func)
                bfl_pkg::FN_ALLOC: begin
                    if (r_top == '0) begin
                        n_valid = 1'b1;
                        st      = bfl_pkg::ST_EMPTY;
                    end else begin
                        // Pop: the response follows once the read returns
                        n_top      = top_m1;
                        n_pop_idx  = rd_addr;
                        n_pop_orig = (top_m1 < r_low);
                        n_low      = (top_m1 < r_low) ? top_m1 : r_low;
                        if (r_hand != '1) begin
                            n_hand = r_hand + CNT_W'(1);
                        end
                    end
                end
                bfl_pkg::FN_FREE: begin
                    n_valid = 1'b1;
                    if (!id_ok) begin
                        st = bfl_pkg::ST_RANGE;
                    end else begin
                        do_clr = 1'b1;
                        if (r_hand != '0) begin
                            n_hand = r_hand - CNT_W'(1);
                        end
                        if (r_top >= r_active) begin
                            st = bfl_pkg::ST_FULL;
                        end else begin
                            do_push = 1'b1;
                            n_top   = r_top + CNT_W'(1);
                        end
                    end
                end
                bfl_pkg::FN_MARK: begin
                    n_valid = 1'b1;
                    if (!id_ok) begin
                        st = bfl_pkg::ST_RANGE;
                    end else begin
                        do_set = 1'b1;
                    end
                end
                bfl_pkg::FN_RESET: begin
                    n_valid   = 1'b1;
                    do_reload = 1'b1;
                    n_active  = clamp_size;
                    n_top     = clamp_size;
                    n_low     = clamp_size;
                    n_hand    = '0;
                end
                default: begin
                    // Query and unused codes only report
                    n_valid = 1'b1;
                end
            endcase
            if (n_valid) begin
                n_rsp.status     = st;
                n_rsp.granted_id = '0;
                n_rsp.free_count = n_top;
                n_rsp.used_count = n_hand;
            end
        end
    end

    // Stack memory: write on push, read the top entry every cycle
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_top[ID_W-1:0]] <= i_cmd.buffer_id;
        end
        r_rdata <= mem[rd_addr];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rsp      <= n_rsp;
        r_pop_idx  <= n_pop_idx;
        r_pop_orig <= n_pop_orig;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= bfl_pkg::POOL_SIZE_RST;
            r_active    <= CNT_W'(bfl_pkg::NUM_BUFS);
            r_top       <= CNT_W'(bfl_pkg::NUM_BUFS);
            r_low       <= CNT_W'(bfl_pkg::NUM_BUFS);
            r_hand      <= '0;
            r_valid     <= 1'b0;
            r_in_use    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_pool_size <= i_cfg_wdata;
            end
            r_active <= n_active;
            r_top    <= n_top;
            r_low    <= n_low;
            r_hand   <= n_hand;
            r_valid  <= n_valid;
            if (do_reload) begin
                r_in_use <= '0;
            end else if (do_set) begin
                r_in_use[i_cmd.buffer_id] <= 1'b1;
            end else if (do_clr) begin
                r_in_use[i_cmd.buffer_id] <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_top_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= r_active)
        else $error("stack top above active pool size");

    a_low_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_top)
        else $error("low mark above stack top");

    a_finish_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.finish |=> (r_valid && r_rsp.status == bfl_pkg::ST_OK))
        else $error("pop did not produce an ok beat");

    a_free_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.accept && !i_ctl.finish && i_cmd.func == bfl_pkg::FN_FREE && id_ok)
        |=> !r_in_use[$past(i_cmd.buffer_id)])
        else $error("free left the in-use bit set");
`endif

endmodule
`default_nettype wire

FILE: rtl/buffer_id_free_list_pool.sv
// Buffer-ID pool: a LIFO free stack of IDs with per-buffer in-use bits
// and a count of buffers handed out.
// Command channel: a beat {func, buffer_id} is taken at a clock edge with
// start high and busy low. Response channel: o_valid marks each response
// beat {status, granted_id, free_count, used_count} for one cycle; the
// receiver cannot stall it, so it must take every beat.
// Responses: free, mark, query, pool reset and an allocate on an empty
// stack answer in the cycle after the command; an allocate that pops goes
// through the registered stack read and then the response register; busy
// is high meanwhile. Throughput: one command per cycle while busy is low.
// Config: i_cfg_we/i_cfg_wdata write pool_size, used at the next pool
// reset command; hardware reset restores it to 64. Write it only while idle.
// Reset (i_rst_n low, synchronous): pool of 64 IDs, highest pops first,
// in-use bits and used count cleared. No memory sweep: entries not yet
// pushed since a reload read back as their own index.
`default_nettype none
module buffer_id_free_list_pool (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [bfl_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  wire logic                       start,
    output logic                            busy,
    input  wire bfl_pkg::t_cmd              i_cmd,
    output logic                            o_valid,
    output bfl_pkg::t_rsp                   o_rsp
);

    bfl_pkg::t_ctl_cmd ctl_cmd;
    bfl_pkg::t_dp_sts  dp_sts;

    bfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (dp_sts),
        .o_cmd   (ctl_cmd)
    );

    bfl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_cmd),
        .i_ctl       (ctl_cmd),
        .o_sts       (dp_sts),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp)
    );

endmodule
`default_nettype wire
